>>> hw/rtl/fmms_pkg.sv
// ----------------------------------------------------------------------------
// fmms_pkg
// Shared constants and float compare helpers for the min/max/minabs stats.
// ----------------------------------------------------------------------------
`default_nettype none
package fmms_pkg;

  localparam int unsigned COUNT_WIDTH = 32;

  localparam logic [31:0] POS_MAX_BITS = 32'h7F7F_FFFF;
  localparam logic [31:0] NEG_MAX_BITS = 32'hFF7F_FFFF;

  typedef enum logic [1:0] {
    REG_SPECIAL_ENABLE = 2'd0,
    REG_SPECIAL_VALUE  = 2'd1,
    REG_IGNORE_MASK    = 2'd2
  } reg_idx_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [31:0] max_bits;
    logic [31:0] min_bits;
    logic [31:0] min_abs_bits;
    count_t      tally;
  } accum_t;

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    is_zero = (a[30:0] == 31'd0);
  endfunction

  // a < b in IEEE order; false if either is nan, zeros compare equal
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (a[31]) begin
      r = (a[30:0] > b[30:0]);
    end else begin
      r = (a[30:0] < b[30:0]);
    end
    f_lt = r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fmms_update.sv
// ----------------------------------------------------------------------------
// fmms_update
// Combinational accumulator update for one registered sample.
// ----------------------------------------------------------------------------
`default_nettype none
module fmms_update (
  input  wire logic               special_enable,
  input  wire logic [31:0]        special_value_bits,
  input  wire logic [31:0]        ignore_mask,
  input  wire logic [31:0]        sample,
  input  wire fmms_pkg::accum_t   acc,
  output fmms_pkg::accum_t        acc_upd
);

  logic        missing;
  logic [31:0] mag;

  always_comb begin
    missing = special_enable &&
              ((sample & ~ignore_mask) == (special_value_bits & ~ignore_mask));
    mag     = {1'b0, sample[30:0]};
    acc_upd = acc;
    if (missing) begin
      if (acc.tally != {fmms_pkg::COUNT_WIDTH{1'b1}}) begin
        acc_upd.tally = acc.tally + fmms_pkg::count_t'(1);
      end
    end else begin
      if (fmms_pkg::f_lt(acc.max_bits, sample)) acc_upd.max_bits = sample;
      if (fmms_pkg::f_lt(sample, acc.min_bits)) acc_upd.min_bits = sample;
      if (!fmms_pkg::is_zero(sample) && fmms_pkg::f_lt(mag, acc.min_abs_bits)) begin
        acc_upd.min_abs_bits = mag;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/float_min_max_minabs_stats.sv
// ----------------------------------------------------------------------------
// float_min_max_minabs_stats
// Streaming fp32 max / min / smallest nonzero magnitude with missing counts.
// ----------------------------------------------------------------------------
// result path: a last item is registered in stage 1, then its result in the result register
// throughput: one item per cycle while stage 1 is not stalled; the accumulator
//   compare-select loop through acc_r is the path that sets it
// stalls: a last item waits in stage 1 while the previous result is not taken
// reset: synchronous active-low; clears config and valid registers, accumulators to
//   -FLT_MAX / FLT_MAX / FLT_MAX / 0, no pending result
`default_nettype none
module float_min_max_minabs_stats (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_sample_bits,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_max_bits,
  output logic [31:0]      out_min_bits,
  output logic [31:0]      out_min_abs_bits,
  output logic [31:0]      out_missing_count
);

  logic             special_enable_r;
  logic [31:0]      special_value_r;
  logic [31:0]      ignore_mask_r;
  logic             s1_valid_r;
  logic [31:0]      s1_sample_r;
  logic             s1_last_r;
  fmms_pkg::accum_t acc_r, acc_upd, acc_nxt, acc_clr;
  logic             res_valid_r;
  fmms_pkg::accum_t res_r;
  logic             s1_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      special_enable_r <= 1'b0;
      special_value_r  <= '0;
      ignore_mask_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fmms_pkg::REG_SPECIAL_ENABLE: special_enable_r <= cfg_data[0];
        fmms_pkg::REG_SPECIAL_VALUE:  special_value_r  <= cfg_data;
        fmms_pkg::REG_IGNORE_MASK:    ignore_mask_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // a last item waits in stage 1 while the result register is still full
  assign s1_stall = s1_valid_r && s1_last_r && res_valid_r && !out_ready;
  assign in_ready = !s1_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_stall && in_valid) begin
      s1_sample_r <= in_sample_bits;
      s1_last_r   <= in_last_item;
    end
  end

  fmms_update u_update (
    .special_enable     (special_enable_r),
    .special_value_bits (special_value_r),
    .ignore_mask        (ignore_mask_r),
    .sample             (s1_sample_r),
    .acc                (acc_r),
    .acc_upd            (acc_upd)
  );

  always_comb begin
    acc_clr.max_bits     = fmms_pkg::NEG_MAX_BITS;
    acc_clr.min_bits     = fmms_pkg::POS_MAX_BITS;
    acc_clr.min_abs_bits = fmms_pkg::POS_MAX_BITS;
    acc_clr.tally        = '0;
    acc_nxt = acc_r;
    if (s1_valid_r && !s1_stall) begin
      acc_nxt = s1_last_r ? acc_clr : acc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= acc_clr;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_last_r && !s1_stall) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_last_r && !s1_stall) begin
      res_r <= acc_upd;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_max_bits     = res_r.max_bits;
  assign out_min_bits     = res_r.min_bits;
  assign out_min_abs_bits = res_r.min_abs_bits;
  assign out_missing_count = (res_r.tally > fmms_pkg::count_t'(32'hFFFF_FFFF)) ?
                             32'hFFFF_FFFF : 32'(res_r.tally);

  // a stalled last item never loses its slot
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_stall |=> s1_valid_r && s1_last_r)
    else $error("stalled item dropped");

  // pending result kept until taken
  a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("result changed while waiting");

  // accumulators return to reset after a last item; checked on the tally
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && !s1_stall |=> acc_r.tally == '0)
    else $error("tally not cleared");

endmodule
`default_nettype wire

>>> test/float_min_max_minabs_stats_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_min_max_minabs_stats_tb
// Streams fp32 data sets through the stats block under several missing-value
// settings with random source and sink stalls. A bit-level model of the
// reduction predicts each data-set result and the monitor checks it.
// ----------------------------------------------------------------------------
module float_min_max_minabs_stats_tb;

  localparam logic [1:0] REG_OUT_OF_RANGE = 2'd3;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [31:0] max_bits;
    logic [31:0] min_bits;
    logic [31:0] min_abs_bits;
    logic [31:0] missing;
  } totals_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_sample_bits = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_max_bits, out_min_bits, out_min_abs_bits, out_missing_count;

  float_min_max_minabs_stats DUT (.*);

  always #10 clk = ~clk;

  // register copies and running totals of the prediction
  logic        match_en = 1'b0;
  logic [31:0] match_bits = '0;
  logic [31:0] match_mask = '0;
  logic [31:0] acc_max = fmms_pkg::NEG_MAX_BITS;
  logic [31:0] acc_min = fmms_pkg::POS_MAX_BITS;
  logic [31:0] acc_min_abs = fmms_pkg::POS_MAX_BITS;
  logic [31:0] acc_missing = '0;

  sample_t pending_samples[$];
  totals_t expected_totals[$];
  int      errors = 0;
  int      idle_pct = 7;
  logic    took = 1'b0;

  function automatic logic nan_bits(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  // maps fp32 onto an unsigned key with the same order; both zeros share one key
  function automatic logic [31:0] order_key(logic [31:0] a);
    if (a[30:0] == 0) return 32'h8000_0000;
    return a[31] ? ~a : (a | 32'h8000_0000);
  endfunction

  function automatic logic fp_less(logic [31:0] a, logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return 1'b0;
    return order_key(a) < order_key(b);
  endfunction

  task automatic reduce_sample(logic [31:0] s, logic last);
    logic [31:0] mag;
    mag = s & 32'h7FFF_FFFF;
    if (match_en && ((s & ~match_mask) == (match_bits & ~match_mask))) begin
      if (acc_missing != 32'hFFFF_FFFF) acc_missing = acc_missing + 1;
    end else begin
      if (fp_less(acc_max, s)) acc_max = s;
      if (fp_less(s, acc_min)) acc_min = s;
      if (mag != 0 && fp_less(mag, acc_min_abs)) acc_min_abs = mag;
    end
    if (last) begin
      expected_totals.push_back('{acc_max, acc_min, acc_min_abs, acc_missing});
      acc_max = fmms_pkg::NEG_MAX_BITS;
      acc_min = fmms_pkg::POS_MAX_BITS;
      acc_min_abs = fmms_pkg::POS_MAX_BITS;
      acc_missing = '0;
    end
  endtask

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    totals_t exp_t;
    took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) reduce_sample(in_sample_bits, in_last_item);
    if (rst_n && out_valid && out_ready) begin
      if (expected_totals.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_t = expected_totals.pop_front();
        if (out_max_bits !== exp_t.max_bits) begin
          $error("max_bits exp %h got %h", exp_t.max_bits, out_max_bits);
          errors++;
        end
        if (out_min_bits !== exp_t.min_bits) begin
          $error("min_bits exp %h got %h", exp_t.min_bits, out_min_bits);
          errors++;
        end
        if (out_min_abs_bits !== exp_t.min_abs_bits) begin
          $error("min_abs_bits exp %h got %h", exp_t.min_abs_bits, out_min_abs_bits);
          errors++;
        end
        if (out_missing_count !== exp_t.missing) begin
          $error("missing_count exp %h got %h", exp_t.missing, out_missing_count);
          errors++;
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    sample_t s;
    out_ready <= ($urandom_range(99) >= idle_pct);
    if (rst_n && (!in_valid || took)) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_sample_bits <= s.sample;
        in_last_item <= s.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      fmms_pkg::REG_SPECIAL_ENABLE: match_en = val[0];
      fmms_pkg::REG_SPECIAL_VALUE:  match_bits = val;
      fmms_pkg::REG_IGNORE_MASK:    match_mask = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_samples.size() == 0 && !in_valid && expected_totals.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup(logic en, logic [31:0] pat, logic [31:0] mask);
    drain();
    write_reg(fmms_pkg::REG_SPECIAL_ENABLE, {31'd0, en});
    write_reg(fmms_pkg::REG_SPECIAL_VALUE, pat);
    write_reg(fmms_pkg::REG_IGNORE_MASK, mask);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'h0000_0000 | ($urandom_range(1) << 31);
      1: return {$urandom_range(1) == 1, 8'hFF, 23'd0};
      2: return {$urandom_range(1) == 1, 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      3: return {$urandom_range(1) == 1, 31'h7F7F_FFFF};
      4: return {$urandom_range(1) == 1, 8'd0, 23'($urandom)};
      5, 6: return (match_bits & ~match_mask) | ($urandom & match_mask);
      7: return {$urandom_range(1) == 1, 8'($urandom_range(120, 134)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_sets(int n_items);
    int len;
    while (n_items > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      for (int k = 1; k <= len; k++) pending_samples.push_back('{pick_sample(), k == len});
      n_items -= len;
    end
  endtask

  initial begin
    logic [31:0] dir[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: specials with matching off, single-item and all-zero sets
    dir = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
            32'hFFC0_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001,
            32'h3F80_0000, 32'hC000_0000};
    foreach (dir[k]) pending_samples.push_back('{dir[k], k == dir.size() - 1});
    pending_samples.push_back('{32'h8000_0000, 1'b0});
    pending_samples.push_back('{32'h0000_0000, 1'b1});
    pending_samples.push_back('{32'h7FC0_0000, 1'b0});
    pending_samples.push_back('{32'hFFFF_FFFF, 1'b1});
    pending_samples.push_back('{32'h4049_0FDB, 1'b1});

    // quiet nan 7FC0_0000 is the missing marker; out-of-range index must be ignored
    setup(1'b1, 32'h7FC0_0000, 32'h0000_0000);
    write_reg(REG_OUT_OF_RANGE, 32'hFFFF_FFFF);
    dir = '{32'h7FC0_0000, 32'h3F80_0000, 32'h7FC0_0000, 32'h7FC0_0001, 32'hBF80_0000};
    foreach (dir[k]) pending_samples.push_back('{dir[k], k == dir.size() - 1});
    // everything ignored by the mask: every value is missing
    setup(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    for (int k = 0; k < 4; k++) pending_samples.push_back('{pick_sample(), k == 3});
    setup(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    pending_samples.push_back('{32'hFFFF_FFFF, 1'b0});
    pending_samples.push_back('{32'h3F80_0000, 1'b1});

    // random phases, one stretch without stalls
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: setup($urandom_range(1), $urandom, $urandom & $urandom);
        1: setup(1'b1, 32'hC61C_3C00, 32'h0000_00FF);
        2: setup(1'b1, $urandom, 32'h0000_0000);
        default: setup(1'b0, $urandom, $urandom);
      endcase
      idle_pct = (p == 5) ? 0 : 7;
      queue_sets(200);
    end
    drain();
    if (errors == 0)
      $display("float_min_max_minabs_stats verification clean");
    else
      $display("float_min_max_minabs_stats verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("float_min_max_minabs_stats verification failed");
    $finish;
  end

endmodule
